// ----- rtl/arprsp_pkg.sv -----
package arprsp_pkg;

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 48;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWERED_IP = 8'd1;

  localparam logic [5:0] POS_SRC_LO   = 6'd6;
  localparam logic [5:0] POS_SRC_HI   = 6'd12;
  localparam logic [5:0] POS_ETYPE_HI = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO = 6'd13;
  localparam logic [5:0] POS_HTYPE_HI = 6'd14;
  localparam logic [5:0] POS_HTYPE_LO = 6'd15;
  localparam logic [5:0] POS_PTYPE_HI = 6'd16;
  localparam logic [5:0] POS_PTYPE_LO = 6'd17;
  localparam logic [5:0] POS_HLEN     = 6'd18;
  localparam logic [5:0] POS_PLEN     = 6'd19;
  localparam logic [5:0] POS_OPER_HI  = 6'd20;
  localparam logic [5:0] POS_OPER_LO  = 6'd21;
  localparam logic [5:0] POS_SMAC_LO  = 6'd22;
  localparam logic [5:0] POS_SIP_LO   = 6'd28;
  localparam logic [5:0] POS_TMAC_LO  = 6'd32;
  localparam logic [5:0] POS_TIP_LO   = 6'd38;
  localparam logic [5:0] POS_LAST     = 6'd41;
  localparam logic [5:0] FRAME_LEN    = 6'd42;
  localparam logic [5:0] POS_MAX      = 6'd63;

  localparam logic [7:0] ETYPE_ARP_HI = 8'h08;
  localparam logic [7:0] ETYPE_ARP_LO = 8'h06;
  localparam logic [7:0] HTYPE_HI     = 8'h00;
  localparam logic [7:0] HTYPE_LO     = 8'h01;
  localparam logic [7:0] PTYPE_HI     = 8'h08;
  localparam logic [7:0] PTYPE_LO     = 8'h00;
  localparam logic [7:0] HLEN         = 8'd6;
  localparam logic [7:0] PLEN         = 8'd4;
  localparam logic [7:0] OPER_HI      = 8'h00;
  localparam logic [7:0] OPER_REQ     = 8'h01;
  localparam logic [7:0] OPER_REPLY   = 8'h02;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_t;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
  } peer_t;

  // byte k of a big-endian value, k = 0 is the most significant
  function automatic logic [7:0] be6(logic [47:0] v, logic [2:0] k);
    logic [47:0] s;
    s = v << {k, 3'b000};
    return s[47:40];
  endfunction

  function automatic logic [7:0] be4(logic [31:0] v, logic [1:0] k);
    logic [31:0] s;
    s = v << {k, 3'b000};
    return s[31:24];
  endfunction

  function automatic logic [7:0] reply_byte(logic [5:0] i, peer_t p,
                                            logic [47:0] mac, logic [31:0] ip);
    logic [5:0] d6;
    logic [5:0] d22;
    logic [5:0] d28;
    logic [5:0] d32;
    logic [5:0] d38;
    logic [7:0] b;
    d6  = i - POS_SRC_LO;
    d22 = i - POS_SMAC_LO;
    d28 = i - POS_SIP_LO;
    d32 = i - POS_TMAC_LO;
    d38 = i - POS_TIP_LO;
    b   = 8'h00;
    if (i < POS_SRC_LO) begin
      b = be6(p.src_mac, i[2:0]);
    end else if (i < POS_SRC_HI) begin
      b = be6(mac, d6[2:0]);
    end else if (i < POS_SMAC_LO) begin
      unique case (i)
        POS_ETYPE_HI: b = ETYPE_ARP_HI;
        POS_ETYPE_LO: b = ETYPE_ARP_LO;
        POS_HTYPE_HI: b = HTYPE_HI;
        POS_HTYPE_LO: b = HTYPE_LO;
        POS_PTYPE_HI: b = PTYPE_HI;
        POS_PTYPE_LO: b = PTYPE_LO;
        POS_HLEN:     b = HLEN;
        POS_PLEN:     b = PLEN;
        POS_OPER_HI:  b = OPER_HI;
        default:      b = OPER_REPLY;
      endcase
    end else if (i < POS_SIP_LO) begin
      b = be6(mac, d22[2:0]);
    end else if (i < POS_TMAC_LO) begin
      b = be4(ip, d28[1:0]);
    end else if (i < POS_TIP_LO) begin
      b = be6(p.sender_mac, d32[2:0]);
    end else begin
      b = be4(p.sender_ip, d38[1:0]);
    end
    return b;
  endfunction

endpackage

// ----- rtl/arprsp_front.sv -----
module arprsp_front
  import arprsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rx_t         in_data,
  input  logic [31:0] answered_ip,
  input  logic        q_full,
  output logic        q_push,
  output peer_t       q_wdata
);

  logic [5:0]  pos_r, pos_nxt;
  logic        match_r, match_nxt;
  logic [47:0] src_r, src_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic        accept;
  logic        check;
  logic [7:0]  expect_b;
  logic        match_chk;
  logic [5:0]  dtip;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign dtip     = pos_r - POS_TIP_LO;

  always_comb begin
    src_nxt   = src_r;
    smac_nxt  = smac_r;
    sip_nxt   = sip_r;
    match_chk = match_r;
    check     = 1'b1;
    expect_b  = 8'h00;
    if (pos_r >= FRAME_LEN) begin
      match_chk = 1'b0;
    end else if (pos_r >= POS_SRC_LO && pos_r < POS_SRC_HI) begin
      src_nxt = {src_r[39:0], in_data.rx_byte};
    end else if (pos_r >= POS_SMAC_LO && pos_r < POS_SIP_LO) begin
      smac_nxt = {smac_r[39:0], in_data.rx_byte};
    end else if (pos_r >= POS_SIP_LO && pos_r < POS_TMAC_LO) begin
      sip_nxt = {sip_r[23:0], in_data.rx_byte};
    end else begin
      unique case (pos_r)
        POS_HTYPE_HI: expect_b = HTYPE_HI;
        POS_HTYPE_LO: expect_b = HTYPE_LO;
        POS_PTYPE_HI: expect_b = PTYPE_HI;
        POS_PTYPE_LO: expect_b = PTYPE_LO;
        POS_HLEN:     expect_b = HLEN;
        POS_PLEN:     expect_b = PLEN;
        POS_OPER_HI:  expect_b = OPER_HI;
        POS_OPER_LO:  expect_b = OPER_REQ;
        default: begin
          if (pos_r >= POS_TIP_LO) begin
            expect_b = be4(answered_ip, dtip[1:0]);
          end else begin
            check = 1'b0;
          end
        end
      endcase
      if (check && in_data.rx_byte != expect_b) begin
        match_chk = 1'b0;
      end
    end

    q_push = 1'b0;
    if (in_data.rx_last) begin
      pos_nxt   = '0;
      match_nxt = 1'b1;
      q_push    = accept && match_chk && (pos_r == POS_LAST);
    end else begin
      pos_nxt   = (pos_r < POS_MAX) ? pos_r + 6'd1 : pos_r;
      match_nxt = match_chk;
    end
  end

  assign q_wdata = '{src_mac: src_r, sender_mac: smac_r, sender_ip: sip_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      match_r <= 1'b1;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r  <= src_nxt;
      smac_r <= smac_nxt;
      sip_r  <= sip_nxt;
    end
  end

endmodule

// ----- rtl/arprsp_queue.sv -----
module arprsp_queue
  import arprsp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  peer_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output peer_t rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  peer_t            mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/arprsp_back.sv -----
module arprsp_back
  import arprsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  peer_t       q_rdata,
  output logic        q_pop,
  input  logic [47:0] local_mac,
  input  logic [31:0] answered_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output tx_t         out_data
);

  logic [5:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  tx_t        out_data_r;
  logic       load;
  logic       is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = q_not_empty && (!out_valid_r || !out_stall);
  assign is_last   = (idx_r == POS_LAST);
  assign q_pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      idx_nxt       = is_last ? '0 : idx_r + 6'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.tx_byte <= reply_byte(idx_r, q_rdata, local_mac, answered_ip);
      out_data_r.tx_last <= is_last;
    end
  end

endmodule

// ----- rtl/arp_request_responder_core.sv -----
// Accepts one request byte per cycle; in_stall rises only while the reply queue is full.
// A matching request is queued, and its reply is then loaded into the out_* registers.
// Replies (42 bytes) stream one byte per cycle unless stalled; queue holds QUEUE_DEPTH_P.
// Synchronous active-low reset clears the parser, queue, emitter and both registers.
module arp_request_responder_core
  import arprsp_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rx_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tx_t                   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [47:0] local_mac_r;
  logic [31:0] answered_ip_r;
  logic        q_full;
  logic        q_push;
  peer_t       q_wdata;
  logic        q_pop;
  logic        q_not_empty;
  peer_t       q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r   <= '0;
      answered_ip_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LOCAL_MAC) begin
        local_mac_r <= cfg_data[47:0];
      end else if (cfg_index == CFG_ANSWERED_IP) begin
        answered_ip_r <= cfg_data[31:0];
      end
    end
  end

  arprsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .answered_ip (answered_ip_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  arprsp_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  arprsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .local_mac   (local_mac_r),
    .answered_ip (answered_ip_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
